// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the dual sensor packet select RTL.
// No dependencies; the assertion bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/dsps_pkg.sv -----
// Package for the dual sensor packet select block: constants, codes and types.
// No dependencies.
`default_nettype none

package dsps_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [14:0]        MIN_RANGE_RST = 15'd50;
    localparam logic [14:0]        MAX_RANGE_RST = 15'd2000;
    localparam logic [15:0]        TIMEOUT_RST   = 16'd500;
    localparam logic [14:0]        OFFLINE_RANGE = 15'd32767;
    localparam logic signed [15:0] ANGLE_LIMIT   = 16'sd180;
    localparam logic [15:0]        AGE_MAX       = 16'hFFFF;

    typedef enum logic [1:0] {
        CFG_MIN_RANGE = 2'd0,
        CFG_MAX_RANGE = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_TICK   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               channel;
        logic signed [8:0]  angle;
        logic [14:0]        range;
    } cmd_t;

    typedef struct packed {
        logic [14:0] min_range;
        logic [14:0] max_range;
        logic [15:0] timeout_ticks;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/dsps_front.sv -----
// Front end: assembles per-channel byte packets and classifies each item.
// Depends on dsps_pkg.
`default_nettype none

module dsps_front
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic         opcode,
    input  wire logic         channel,
    input  wire logic [7:0]   data_byte,
    input  wire dsps_pkg::cfg_t cfg,
    output dsps_pkg::cmd_t    cmd
);

    logic [1:0] pos_reg  [2];
    logic [1:0] pos_next [2];
    logic [7:0] buf_reg  [2][3];

    logic [1:0]         pos_sel;
    logic signed [15:0] ang;
    logic [15:0]        rng;
    logic               pass;

    always_comb
    begin
        pos_sel = pos_reg[channel];
        ang     = {buf_reg[channel][1], buf_reg[channel][0]};
        rng     = {data_byte, buf_reg[channel][2]};
        pass    = (ang >= -dsps_pkg::ANGLE_LIMIT) && (ang <= dsps_pkg::ANGLE_LIMIT)
                  && !rng[15]
                  && (rng[14:0] >= cfg.min_range) && (rng[14:0] <= cfg.max_range);

        cmd.channel = channel;
        cmd.angle   = ang[8:0];
        cmd.range   = rng[14:0];
        pos_next    = pos_reg;
        if (opcode)
        begin
            cmd.kind = dsps_pkg::KIND_TICK;
        end
        else if (pos_sel != 2'd3)
        begin
            cmd.kind          = dsps_pkg::KIND_BYTE;
            pos_next[channel] = pos_sel + 2'd1;
        end
        else
        begin
            cmd.kind          = pass ? dsps_pkg::KIND_ACCEPT : dsps_pkg::KIND_REJECT;
            pos_next[channel] = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg[0] <= 2'd0;
            pos_reg[1] <= 2'd0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
        end
    end

    // Packet bytes need no reset: only bytes written earlier in a packet are read
    always_ff @(posedge clk)
    begin
        if (push && !opcode && (pos_sel != 2'd3))
        begin
            buf_reg[channel][pos_sel] <= data_byte;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dsps_queue.sv -----
// Short command queue between front and back end.
// Depends on dsps_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dsps_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire dsps_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output dsps_pkg::cmd_t      head_cmd,
    output logic                full,
    output logic                empty
);

    localparam int DEPTH = dsps_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dsps_pkg::cmd_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full))
    `ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && empty))

endmodule

`default_nettype wire

// ----- hdl/dsps_back.sv -----
// Back end: applies queued commands to channel state and registers each result.
// Depends on dsps_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dsps_back
#(
    parameter int COUNT_WIDTH = dsps_pkg::COUNT_WIDTH_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dsps_pkg::cmd_t cmd,
    input  wire logic           empty,
    input  wire logic [15:0]    timeout_ticks,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [95:0]         m_tdata,
    output logic [1:0]          m_tuser
);

    logic signed [8:0]      angle_reg [2];
    logic signed [8:0]      angle_next [2];
    logic [14:0]            range_reg [2];
    logic [14:0]            range_next [2];
    logic [15:0]            age_reg [2];
    logic [15:0]            age_next [2];
    logic [COUNT_WIDTH-1:0] good_reg [2];
    logic [COUNT_WIDTH-1:0] good_next [2];
    logic [COUNT_WIDTH-1:0] bad_reg [2];
    logic [COUNT_WIDTH-1:0] bad_next [2];

    logic                   m_tvalid_reg;
    logic                   done_reg;
    logic                   accepted_reg;
    logic [90:0]            data_reg;

    logic                   online [2];
    logic [14:0]            eff_range [2];
    logic signed [8:0]      eff_angle [2];
    logic                   left_wins;
    logic [COUNT_WIDTH+31:0] good_wide;
    logic [COUNT_WIDTH+31:0] bad_wide;
    logic [90:0]            data_next;

    // Pop when the output register is free or is being drained this cycle
    assign pop      = !empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, data_reg};
    assign m_tuser  = {accepted_reg, done_reg};

    always_comb
    begin
        angle_next = angle_reg;
        range_next = range_reg;
        age_next   = age_reg;
        good_next  = good_reg;
        bad_next   = bad_reg;
        case (cmd.kind)
            dsps_pkg::KIND_ACCEPT:
            begin
                angle_next[cmd.channel] = cmd.angle;
                range_next[cmd.channel] = cmd.range;
                age_next[cmd.channel]   = 16'd0;
                good_next[cmd.channel]  = good_reg[cmd.channel] + 1'b1;
            end
            dsps_pkg::KIND_REJECT:
            begin
                bad_next[cmd.channel] = bad_reg[cmd.channel] + 1'b1;
            end
            dsps_pkg::KIND_TICK:
            begin
                for (int c = 0; c < 2; c++)
                begin
                    if (age_reg[c] != dsps_pkg::AGE_MAX)
                    begin
                        age_next[c] = age_reg[c] + 16'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        for (int c = 0; c < 2; c++)
        begin
            online[c]    = (age_next[c] <= timeout_ticks);
            eff_range[c] = online[c] ? range_next[c] : dsps_pkg::OFFLINE_RANGE;
            eff_angle[c] = online[c] ? angle_next[c] : 9'sd0;
        end
        left_wins = (eff_range[0] <= eff_range[1]);

        good_wide = {32'd0, good_next[cmd.channel]};
        bad_wide  = {32'd0, bad_next[cmd.channel]};
        data_next = {bad_wide[31:0], good_wide[31:0],
                     {1'b0, left_wins ? eff_range[0] : eff_range[1]},
                     left_wins ? eff_angle[0] : eff_angle[1],
                     online[1], online[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 2; c++)
            begin
                angle_reg[c] <= 9'sd0;
                range_reg[c] <= dsps_pkg::OFFLINE_RANGE;
                age_reg[c]   <= 16'd0;
                good_reg[c]  <= '0;
                bad_reg[c]   <= '0;
            end
            m_tvalid_reg <= 1'b0;
        end
        else if (pop)
        begin
            angle_reg    <= angle_next;
            range_reg    <= range_next;
            age_reg      <= age_next;
            good_reg     <= good_next;
            bad_reg      <= bad_next;
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            done_reg     <= (cmd.kind == dsps_pkg::KIND_ACCEPT)
                            || (cmd.kind == dsps_pkg::KIND_REJECT);
            accepted_reg <= (cmd.kind == dsps_pkg::KIND_ACCEPT);
            data_reg     <= data_next;
        end
    end

    `ASSERT_IMPLY(a_accept_is_done, clk, rst_n, m_tvalid_reg && accepted_reg, done_reg)
    `ASSERT_NEXT(a_accept_clears_age, clk, rst_n,
        pop && cmd.kind == dsps_pkg::KIND_ACCEPT && !cmd.channel, age_reg[0] == 16'd0)
    `ASSERT_NEXT(a_age_saturates, clk, rst_n,
        pop && cmd.kind == dsps_pkg::KIND_TICK && age_reg[1] == dsps_pkg::AGE_MAX,
        age_reg[1] == dsps_pkg::AGE_MAX)

endmodule

`default_nettype wire

// ----- hdl/dual_sensor_packet_select.sv -----
// Dual sensor packet select: top level with configuration registers.
// Depends on dsps_pkg, dsps_front, dsps_queue and dsps_back.
//
// Usage:
//   Input stream (s_*): one item per transfer. s_tuser[0] is the opcode
//   (0 = received byte, 1 = millisecond tick), s_tuser[1] the channel
//   (0 left, 1 right); s_tdata carries the byte. Every fourth byte of a
//   channel closes a little-endian packet (angle, then range).
//   Output stream (m_*): exactly one result per input item, in order.
//   m_tuser flags packet completion and acceptance; m_tdata carries the
//   online flags, the chosen angle and range and the counts of the channel
//   named by the input item.
//   Path: an item is registered in the command queue and then in the
//   output register.
//   Throughput: one item per cycle while m_tready is high; the back end
//   updates all channel state once per item, so the command queue only
//   fills when the receiver stalls.
//   Stall: while m_tready is low the result holds, up to two classified items
//   wait in the queue, and s_tready drops once the queue is full.
//   Reset: clears packet assembly, stored values, ages and counts; ranges
//   restart as 32767 and the registers return to 50, 2000 and 500.
//   Configuration: write with cfg_we/cfg_index/cfg_data while the block is idle.
`default_nettype none

module dual_sensor_packet_select
#(
    parameter int COUNT_WIDTH = dsps_pkg::COUNT_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,   // [0] opcode, [1] channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] left_online, [1] right_online, [10:2] chosen_angle,
    // [26:11] chosen_range, [58:27] channel_good_count,
    // [90:59] channel_bad_count, [95:91] zero
    output logic [95:0]      m_tdata,
    output logic [1:0]       m_tuser    // [0] packet_done, [1] packet_accepted
);

    dsps_pkg::cfg_t cfg_reg;
    dsps_pkg::cmd_t front_cmd;
    dsps_pkg::cmd_t head_cmd;

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // Register writes; an index beyond the register list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_range     <= dsps_pkg::MIN_RANGE_RST;
            cfg_reg.max_range     <= dsps_pkg::MAX_RANGE_RST;
            cfg_reg.timeout_ticks <= dsps_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (dsps_pkg::cfg_index_t'(cfg_index))
                dsps_pkg::CFG_MIN_RANGE: cfg_reg.min_range     <= cfg_data[14:0];
                dsps_pkg::CFG_MAX_RANGE: cfg_reg.max_range     <= cfg_data[14:0];
                dsps_pkg::CFG_TIMEOUT:   cfg_reg.timeout_ticks <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Take an item whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    dsps_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .opcode    (s_tuser[0]),
        .channel   (s_tuser[1]),
        .data_byte (s_tdata),
        .cfg       (cfg_reg),
        .cmd       (front_cmd)
    );

    dsps_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    dsps_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (head_cmd),
        .empty         (q_empty),
        .timeout_ticks (cfg_reg.timeout_ticks),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

`default_nettype wire
